[design/mmdkr_pkg.sv]
// Shared types and constants for the memory map decoder with key ring.
// Used by the front decoder, the transaction queue, the back engine and the top level.
package mmdkr_pkg;

  localparam int ADDR_BITS    = 16;
  localparam int REGION_COUNT = 4;
  localparam int BUS_W        = 16;
  localparam int REGION_W     = 35;
  localparam int CFG_DATA_W   = 56;
  localparam int CFG_IDX_W    = 3;
  localparam int Q_DEPTH      = 2;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);
  localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [REGION_W-1:0]  region_t;
  typedef logic [2:0]           kind_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RUNNING = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT  = 3'd5;

  // Bus opcodes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_KEY   = 2'd2;

  // Region types
  localparam logic [1:0] RT_NONE = 2'd0;
  localparam logic [1:0] RT_ROM  = 2'd1;
  localparam logic [1:0] RT_RAM  = 2'd2;
  localparam logic [1:0] RT_IO   = 2'd3;

  // Result routes
  localparam logic [2:0] ROUTE_UNMAPPED = 3'd0;
  localparam logic [2:0] ROUTE_NONE     = 3'd1;
  localparam logic [2:0] ROUTE_MEM      = 3'd2;
  localparam logic [2:0] ROUTE_IO       = 3'd3;
  localparam logic [2:0] ROUTE_ROM_BLK  = 3'd4;
  localparam logic [2:0] ROUTE_KEY      = 3'd5;
  localparam logic [2:0] ROUTE_KEY_DROP = 3'd6;

  // Transaction kinds decided by the front decoder
  localparam kind_t KIND_ZERO    = 3'd0;
  localparam kind_t KIND_NONE    = 3'd1;
  localparam kind_t KIND_IO      = 3'd2;
  localparam kind_t KIND_ROM_BLK = 3'd3;
  localparam kind_t KIND_RD      = 3'd4;
  localparam kind_t KIND_WR      = 3'd5;
  localparam kind_t KIND_KEY     = 3'd6;

  typedef struct packed {
    logic [7:0]  last_idx;
    logic [15:0] base;
    logic [15:0] tail_addr;
    logic [15:0] head_addr;
  } ring_layout_t;

  typedef struct packed {
    kind_t      kind;
    logic       is_write;
    addr_t      addr;
    logic [7:0] data;
  } q_entry_t;

endpackage

[design/mmdkr_front.sv]
// Front decoder: accepts bus and key transactions and classifies them by region.
// Depends on mmdkr_pkg; feeds mmdkr_queue.
module mmdkr_front (
  input  logic                                                  in_valid,
  output logic                                                  in_stall,
  input  logic [1:0]                                            in_opcode,
  input  logic [15:0]                                           in_address,
  input  logic [7:0]                                            in_write_data,
  input  logic                                                  running,
  input  mmdkr_pkg::region_t [mmdkr_pkg::REGION_COUNT-1:0]      regions,
  output logic                                                  push_valid,
  input  logic                                                  push_stall,
  output mmdkr_pkg::q_entry_t                                   push_entry
);
  import mmdkr_pkg::*;

  addr_t            addr;
  logic [BUS_W-1:0] addr_ext;
  logic             hit;
  logic [1:0]       hit_type;
  logic [BUS_W+1:0] lim;
  kind_t            kind;

  assign addr     = in_address[ADDR_BITS-1:0];
  assign addr_ext = BUS_W'(addr);

  // Walk from lowest priority up so the first matching region wins
  always_comb begin
    hit      = 1'b0;
    hit_type = RT_NONE;
    lim      = '0;
    for (int i = REGION_COUNT - 1; i >= 0; i--) begin
      lim = {2'b00, regions[i][15:0]} + {1'b0, regions[i][32:16]};
      if ((addr_ext >= regions[i][15:0]) && ({2'b00, addr_ext} < lim)) begin
        hit      = 1'b1;
        hit_type = regions[i][34:33];
      end
    end
  end

  always_comb begin
    kind = KIND_ZERO;
    if (in_opcode == OP_KEY) begin
      kind = KIND_KEY;
    end else if ((in_opcode == OP_READ || in_opcode == OP_WRITE) && hit) begin
      case (hit_type)
        RT_NONE: kind = KIND_NONE;
        RT_IO:   kind = KIND_IO;
        default: begin
          if (in_opcode == OP_READ) kind = KIND_RD;
          else if (hit_type == RT_ROM && running) kind = KIND_ROM_BLK;
          else kind = KIND_WR;
        end
      endcase
    end
  end

  assign push_valid          = in_valid;
  assign in_stall            = push_stall;
  assign push_entry.kind     = kind;
  assign push_entry.is_write = (in_opcode == OP_WRITE);
  assign push_entry.addr     = addr;
  assign push_entry.data     = in_write_data;

endmodule

[design/mmdkr_queue.sv]
// Short transaction queue between the front decoder and the back engine.
// Depends on mmdkr_pkg for the entry type and depth.
module mmdkr_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_stall,
  input  mmdkr_pkg::q_entry_t  push_entry,
  output logic                 pop_valid,
  input  logic                 pop_stall,
  output mmdkr_pkg::q_entry_t  pop_entry
);
  import mmdkr_pkg::*;

  q_entry_t           slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr_r, wptr_nxt;
  logic [Q_PTR_W-1:0] rptr_r, rptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               push, pop;

  assign push_stall = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_entry  = slot_r[rptr_r];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wptr_r] <= push_entry;
  end

endmodule

[design/mmdkr_back.sv]
// Back engine: carries out queued transactions on the single-port backing store
// and sequences key ring updates. Depends on mmdkr_pkg.
module mmdkr_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  output logic                    q_stall,
  input  mmdkr_pkg::q_entry_t     q_entry,
  input  mmdkr_pkg::ring_layout_t layout,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_read_data,
  output logic [2:0]              out_route,
  output logic                    out_io_strobe,
  output logic                    out_io_is_write,
  output logic [15:0]             out_io_address,
  output logic [7:0]              out_io_write_data
);
  import mmdkr_pkg::*;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_RD        = 3'd1;
  localparam logic [2:0] ST_KEY_TAIL  = 3'd2;
  localparam logic [2:0] ST_KEY_CHAR  = 3'd3;
  localparam logic [2:0] ST_KEY_HEAD  = 3'd4;
  localparam logic [2:0] ST_KEY_TAILW = 3'd5;

  function automatic logic [7:0] ring_advance(input logic [7:0] idx, input logic [7:0] last);
    logic [7:0] n;
    n = idx + 8'd1;
    return (n > last) ? 8'd0 : n;
  endfunction

  logic [2:0]  state_r, state_nxt;
  q_entry_t    cur_r, cur_nxt;
  logic [7:0]  head_r, head_nxt;
  logic [7:0]  next_head_r, next_head_nxt;
  logic [7:0]  next_tail_r, next_tail_nxt;
  logic        dropped_r, dropped_nxt;

  logic [7:0]  store_mem [2**ADDR_BITS];
  logic [7:0]  mem_rdata_r;
  logic        mem_we;
  addr_t       mem_addr;
  logic [7:0]  mem_wdata;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_read_data_r;
  logic [2:0]  out_route_r;
  logic        out_io_strobe_r;
  logic        out_io_is_write_r;
  logic [15:0] out_io_address_r;
  logic [7:0]  out_io_write_data_r;

  logic        out_free, pop, out_load;
  logic [7:0]  res_read_data;
  logic [2:0]  res_route;
  logic        res_io_strobe;
  logic        res_io_is_write;
  logic [15:0] res_io_address;
  logic [7:0]  res_io_write_data;
  logic [7:0]  tail, nt, nh;
  addr_t       head_addr, tail_addr;

  assign out_free  = !out_valid_r || !out_stall;
  assign q_stall   = !((state_r == ST_IDLE) && out_free);
  assign pop       = q_valid && !q_stall;
  assign head_addr = layout.head_addr[ADDR_BITS-1:0];
  assign tail_addr = layout.tail_addr[ADDR_BITS-1:0];
  assign tail      = mem_rdata_r;
  assign nt        = ring_advance(tail, layout.last_idx);
  assign nh        = (nt == head_r) ? ring_advance(head_r, layout.last_idx) : head_r;

  always_comb begin
    state_nxt         = state_r;
    cur_nxt           = cur_r;
    head_nxt          = head_r;
    next_head_nxt     = next_head_r;
    next_tail_nxt     = next_tail_r;
    dropped_nxt       = dropped_r;
    mem_we            = 1'b0;
    mem_addr          = cur_r.addr;
    mem_wdata         = cur_r.data;
    out_load          = 1'b0;
    res_read_data     = '0;
    res_route         = ROUTE_UNMAPPED;
    res_io_strobe     = 1'b0;
    res_io_is_write   = 1'b0;
    res_io_address    = '0;
    res_io_write_data = '0;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          cur_nxt  = q_entry;
          mem_addr = q_entry.addr;
          case (q_entry.kind)
            KIND_RD: state_nxt = ST_RD;
            KIND_KEY: begin
              mem_addr  = head_addr;
              state_nxt = ST_KEY_TAIL;
            end
            KIND_WR: begin
              mem_we    = 1'b1;
              mem_wdata = q_entry.data;
              out_load  = 1'b1;
              res_route = ROUTE_MEM;
            end
            KIND_NONE: begin
              out_load  = 1'b1;
              res_route = ROUTE_NONE;
            end
            KIND_IO: begin
              out_load          = 1'b1;
              res_route         = ROUTE_IO;
              res_io_strobe     = 1'b1;
              res_io_is_write   = q_entry.is_write;
              res_io_address    = BUS_W'(q_entry.addr);
              res_io_write_data = q_entry.is_write ? q_entry.data : 8'd0;
            end
            KIND_ROM_BLK: begin
              out_load  = 1'b1;
              res_route = ROUTE_ROM_BLK;
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      ST_RD: begin
        out_load      = 1'b1;
        res_route     = ROUTE_MEM;
        res_read_data = mem_rdata_r;
        state_nxt     = ST_IDLE;
      end
      ST_KEY_TAIL: begin
        head_nxt  = mem_rdata_r;
        mem_addr  = tail_addr;
        state_nxt = ST_KEY_CHAR;
      end
      ST_KEY_CHAR: begin
        // Store the character at base+tail, wrapping in the address space
        mem_we        = 1'b1;
        mem_addr      = ADDR_BITS'(layout.base) + ADDR_BITS'(tail);
        mem_wdata     = cur_r.data;
        next_tail_nxt = nt;
        next_head_nxt = nh;
        dropped_nxt   = (nt == head_r);
        state_nxt     = ST_KEY_HEAD;
      end
      ST_KEY_HEAD: begin
        mem_we    = 1'b1;
        mem_addr  = head_addr;
        mem_wdata = next_head_r;
        state_nxt = ST_KEY_TAILW;
      end
      ST_KEY_TAILW: begin
        // Tail goes last so it wins where the addresses coincide
        mem_we    = 1'b1;
        mem_addr  = tail_addr;
        mem_wdata = next_tail_r;
        out_load  = 1'b1;
        res_route = dropped_r ? ROUTE_KEY_DROP : ROUTE_KEY;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    head_r      <= head_nxt;
    next_head_r <= next_head_nxt;
    next_tail_r <= next_tail_nxt;
    dropped_r   <= dropped_nxt;
    if (out_load) begin
      out_read_data_r     <= res_read_data;
      out_route_r         <= res_route;
      out_io_strobe_r     <= res_io_strobe;
      out_io_is_write_r   <= res_io_is_write;
      out_io_address_r    <= res_io_address;
      out_io_write_data_r <= res_io_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) store_mem[mem_addr] <= mem_wdata;
    mem_rdata_r <= store_mem[mem_addr];
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_read_data_r;
  assign out_route         = out_route_r;
  assign out_io_strobe     = out_io_strobe_r;
  assign out_io_is_write   = out_io_is_write_r;
  assign out_io_address    = out_io_address_r;
  assign out_io_write_data = out_io_write_data_r;

  a_busy_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !out_valid_r)
    else $error("result held while engine busy");

  a_io_strobe_route: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_io_strobe_r == (out_route_r == ROUTE_IO)))
    else $error("io strobe disagrees with route");

  a_key_start: assert property (@(posedge clk) disable iff (!rst_n)
    pop && q_entry.kind == KIND_KEY |=> state_r == ST_KEY_TAIL)
    else $error("key push did not start ring sequence");

  a_key_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_KEY_TAILW |=>
      out_valid_r && (out_route_r == ROUTE_KEY || out_route_r == ROUTE_KEY_DROP))
    else $error("key push gave no key result");

endmodule

[design/memory_map_decoder_with_key_ring.sv]
// Results are registered at the back engine output. Throughput: one write, IO or
// unmapped access per cycle while out_stall is low; a read passes through ST_RD and a key
// push through ST_KEY_TAIL to ST_KEY_TAILW; meanwhile the engine takes no new transaction.
// Reset clears control state and all configuration registers; the backing store is not
// cleared and holds undefined contents until written.
// Depends on mmdkr_pkg, mmdkr_front, mmdkr_queue and mmdkr_back.
module memory_map_decoder_with_key_ring (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mmdkr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mmdkr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_opcode,
  input  logic [15:0]                       in_address,
  input  logic [7:0]                        in_write_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_read_data,
  output logic [2:0]                        out_route,
  output logic                              out_io_strobe,
  output logic                              out_io_is_write,
  output logic [15:0]                       out_io_address,
  output logic [7:0]                        out_io_write_data
);
  import mmdkr_pkg::*;

  logic                          running_r;
  region_t [REGION_COUNT-1:0]    regions_r;
  ring_layout_t                  layout_r;

  logic                          push_valid, push_stall;
  q_entry_t                      push_entry;
  logic                          q_valid, q_stall;
  q_entry_t                      q_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      regions_r <= '0;
      layout_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_RUNNING) running_r <= cfg_data[0];
      if (cfg_index == CFG_LAYOUT) layout_r <= ring_layout_t'(cfg_data);
      for (int i = 0; i < REGION_COUNT; i++) begin
        if (cfg_index == CFG_REGION0 + CFG_IDX_W'(i)) regions_r[i] <= cfg_data[REGION_W-1:0];
      end
    end
  end

  mmdkr_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .running       (running_r),
    .regions       (regions_r),
    .push_valid    (push_valid),
    .push_stall    (push_stall),
    .push_entry    (push_entry)
  );

  mmdkr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_entry (push_entry),
    .pop_valid  (q_valid),
    .pop_stall  (q_stall),
    .pop_entry  (q_entry)
  );

  mmdkr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_stall           (q_stall),
    .q_entry           (q_entry),
    .layout            (layout_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_data     (out_read_data),
    .out_route         (out_route),
    .out_io_strobe     (out_io_strobe),
    .out_io_is_write   (out_io_is_write),
    .out_io_address    (out_io_address),
    .out_io_write_data (out_io_write_data)
  );

endmodule
